### sv/vat_pkg.sv
// Shared constants, beat types and sine table builder for the vertex axis transform.
package vat_pkg;

  localparam int COORD_W   = 32;
  localparam int ANGLE_W   = 12;
  localparam int TRIG_W    = 16;
  localparam int TRIG_FRAC = TRIG_W - 1;
  localparam int SCALE_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + TRIG_W;
  localparam int SPROD_W = COORD_W + SCALE_W;
  localparam int RND_W   = SPROD_W - FRAC_W;
  localparam int SUM_W   = RND_W + 1;

  localparam int QUARTER = 1 << (ANGLE_W - 2);
  localparam int IDX_W   = ANGLE_W - 1;
  localparam int MAG_W   = TRIG_W - 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    MODE_TRANSLATE = 3'd0,
    MODE_ROT_X     = 3'd1,
    MODE_ROT_Y     = 3'd2,
    MODE_ROT_Z     = 3'd3,
    MODE_PIV_X     = 3'd4,
    MODE_PIV_Y     = 3'd5,
    MODE_PIV_Z     = 3'd6,
    MODE_SCALE_X   = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_ANGLE    = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_OFFSET_Z = 3'd4,
    REG_SCALE    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } vat_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
  } vat_out_t;

  typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER];

  // Taylor series in Q2.30, rounded half up to Q1.15 and capped
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    logic [63:0] e;
    x    = (HALF_PI_Q30 * 64'(r)) >> (ANGLE_W - 2);
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = ((64'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return e[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int r = 0; r <= QUARTER; r++) begin
      rom[r] = quarter_sine(r);
    end
    return rom;
  endfunction

  function automatic logic [COORD_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] hi_bits;
    hi_bits = v[SUM_W-1:COORD_W-1];
    if (&hi_bits || ~|hi_bits) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

### sv/vat_trig.sv
// Sine and cosine lookup for the configured angle, loaded on an angle write.
module vat_trig
  import vat_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [ANGLE_W-1:0]       code,
  output logic signed [TRIG_W-1:0] sin_q,
  output logic signed [TRIG_W-1:0] cos_q
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [1:0]         quad_s;
  logic [1:0]         quad_c;
  logic [ANGLE_W-1:0] code_c;
  logic [IDX_W-1:0]   idx_s;
  logic [IDX_W-1:0]   idx_c;

  logic [MAG_W-1:0]   sin_mag_r;
  logic [MAG_W-1:0]   cos_mag_r;
  logic               sin_neg_r;
  logic               cos_neg_r;
  logic signed [TRIG_W-1:0] sin_r;
  logic signed [TRIG_W-1:0] cos_r;

  always_comb begin
    code_c = code + ANGLE_W'(QUARTER);
    quad_s = code[ANGLE_W-1:ANGLE_W-2];
    quad_c = code_c[ANGLE_W-1:ANGLE_W-2];
    idx_s  = quad_s[0] ? IDX_W'(QUARTER) - IDX_W'(code[ANGLE_W-3:0])
                       : IDX_W'(code[ANGLE_W-3:0]);
    idx_c  = quad_c[0] ? IDX_W'(QUARTER) - IDX_W'(code_c[ANGLE_W-3:0])
                       : IDX_W'(code_c[ANGLE_W-3:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_mag_r <= '0;
      cos_mag_r <= SINE_ROM[QUARTER];
      sin_neg_r <= 1'b0;
      cos_neg_r <= 1'b0;
    end else if (load) begin
      sin_mag_r <= SINE_ROM[idx_s];
      cos_mag_r <= SINE_ROM[idx_c];
      sin_neg_r <= quad_s[1];
      cos_neg_r <= quad_c[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_r <= '0;
      cos_r <= TRIG_W'(SINE_ROM[QUARTER]);
    end else begin
      sin_r <= sin_neg_r ? -TRIG_W'(sin_mag_r) : TRIG_W'(sin_mag_r);
      cos_r <= cos_neg_r ? -TRIG_W'(cos_mag_r) : TRIG_W'(cos_mag_r);
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

### sv/vertex_axis_transform.sv
// Top level: four-stage vertex transform pipeline with configuration registers.
// One vertex beat is accepted per cycle unless in_stall holds it back; its result passes
// through the stage A, B, C and D registers, the last being the output register.
// The pipeline is four register stages (offset add or pivot subtract, the 33x16 and
// 32x32 multipliers, rounding, pivot add-back with saturation), so a stall on the
// output only stops the stages that are full and bubbles are squeezed out. An angle
// write registers the table magnitudes at the write edge, then the signed sine and
// cosine from them, so a vertex may follow any configuration write in the next
// cycle. Register writes to an index past the scale factor are dropped.
module vertex_axis_transform
  import vat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vat_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vat_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef struct packed {
    logic translate;
    logic pivot;
    logic rot_x;
    logic rot_y;
    logic rot_z;
    logic scale;
  } vat_ctl_t;

  localparam logic signed [PROD_W:0]    ROT_HALF = (PROD_W + 1)'(1 << (TRIG_FRAC - 1));
  localparam logic signed [SPROD_W-1:0] SC_HALF  = SPROD_W'(1 << (FRAC_W - 1));

  // configuration
  mode_t                     mode_r;
  logic signed [COORD_W-1:0] off_x_r;
  logic signed [COORD_W-1:0] off_y_r;
  logic signed [COORD_W-1:0] off_z_r;
  logic signed [SCALE_W-1:0] scale_r;
  logic                      angle_load;
  logic signed [TRIG_W-1:0]  sin_q;
  logic signed [TRIG_W-1:0]  cos_q;
  logic signed [TRIG_W-1:0]  nsin_q;
  vat_ctl_t                  ctl;

  // pipeline control
  logic v_a_r, v_b_r, v_c_r, v_d_r;
  logic mv_a, mv_b, mv_c, mv_d;

  // stage A
  logic signed [DIFF_W-1:0] oa_x, oa_y, oa_z;
  logic signed [DIFF_W-1:0] a_x_nxt, a_y_nxt, a_z_nxt;
  logic signed [DIFF_W-1:0] a_x_r, a_y_r, a_z_r;

  // stage B
  logic signed [DIFF_W-1:0]  op_ya, op_yb, op_za, op_zb, op_xb;
  logic signed [TRIG_W-1:0]  k_xb, k_ya, k_yb, k_za, k_zb;
  logic signed [COORD_W-1:0] sc_op;
  logic signed [PROD_W-1:0]  pxa_nxt, pxb_nxt, pya_nxt, pyb_nxt, pza_nxt, pzb_nxt;
  logic signed [PROD_W-1:0]  pxa_r, pxb_r, pya_r, pyb_r, pza_r, pzb_r;
  logic signed [SPROD_W-1:0] sp_nxt, sp_r;
  logic signed [DIFF_W-1:0]  pass_x_r, pass_y_r, pass_z_r;

  // stage C
  logic signed [PROD_W:0]    rs_x, rs_y, rs_z;
  logic signed [PROD_W:0]    rsh_x, rsh_y, rsh_z;
  logic signed [SPROD_W-1:0] ss, ssh;
  logic signed [RND_W-1:0]   r_x_nxt, r_y_nxt, r_z_nxt;
  logic signed [RND_W-1:0]   r_x_r, r_y_r, r_z_r;

  // stage D
  logic signed [COORD_W-1:0] pv_x, pv_y, pv_z;
  logic signed [SUM_W-1:0]   sum_x, sum_y, sum_z;
  vat_out_t                  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TRANSLATE;
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      scale_r <= SCALE_W'(1 << FRAC_W);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode_r  <= mode_t'(cfg_wdata[2:0]);
        REG_ANGLE:    ;
        REG_OFFSET_X: off_x_r <= cfg_wdata[COORD_W-1:0];
        REG_OFFSET_Y: off_y_r <= cfg_wdata[COORD_W-1:0];
        REG_OFFSET_Z: off_z_r <= cfg_wdata[COORD_W-1:0];
        REG_SCALE:    scale_r <= cfg_wdata[SCALE_W-1:0];
        default:      ;
      endcase
    end
  end

  assign angle_load = cfg_we && (cfg_index == REG_ANGLE);

  vat_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (angle_load),
    .code  (cfg_wdata[ANGLE_W-1:0]),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  assign nsin_q = -sin_q;

  always_comb begin
    ctl = '0;
    unique case (mode_r) inside
      MODE_TRANSLATE:         ctl.translate = 1'b1;
      MODE_ROT_X, MODE_PIV_X: ctl.rot_x     = 1'b1;
      MODE_ROT_Y, MODE_PIV_Y: ctl.rot_y     = 1'b1;
      MODE_ROT_Z, MODE_PIV_Z: ctl.rot_z     = 1'b1;
      MODE_SCALE_X:           ctl.scale     = 1'b1;
      default:                ;
    endcase
    ctl.pivot = (mode_r == MODE_PIV_X) || (mode_r == MODE_PIV_Y) ||
                (mode_r == MODE_PIV_Z);
  end

  // a stage moves when it is empty or the next one moves
  assign mv_d     = !v_d_r || !out_stall;
  assign mv_c     = !v_c_r || mv_d;
  assign mv_b     = !v_b_r || mv_c;
  assign mv_a     = !v_a_r || mv_b;
  assign in_stall = !mv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      if (mv_a) v_a_r <= in_valid;
      if (mv_b) v_b_r <= v_a_r;
      if (mv_c) v_c_r <= v_b_r;
      if (mv_d) v_d_r <= v_c_r;
    end
  end

  // stage A: translate offset or pivot subtract
  always_comb begin
    if (ctl.translate) begin
      oa_x = DIFF_W'(off_x_r);
      oa_y = DIFF_W'(off_y_r);
      oa_z = DIFF_W'(off_z_r);
    end else if (ctl.pivot) begin
      oa_x = -DIFF_W'(off_x_r);
      oa_y = -DIFF_W'(off_y_r);
      oa_z = -DIFF_W'(off_z_r);
    end else begin
      oa_x = '0;
      oa_y = '0;
      oa_z = '0;
    end
    a_x_nxt = DIFF_W'(in_data.in_x) + oa_x;
    a_y_nxt = DIFF_W'(in_data.in_y) + oa_y;
    a_z_nxt = DIFF_W'(in_data.in_z) + oa_z;
  end

  always_ff @(posedge clk) begin
    if (mv_a) begin
      a_x_r <= a_x_nxt;
      a_y_r <= a_y_nxt;
      a_z_r <= a_z_nxt;
    end
  end

  // stage B: products
  always_comb begin
    op_xb = ctl.rot_y ? a_z_r : a_y_r;
    k_xb  = ctl.rot_y ? sin_q : nsin_q;
    op_ya = ctl.rot_x ? a_y_r : a_x_r;
    k_ya  = ctl.rot_x ? cos_q : sin_q;
    op_yb = ctl.rot_x ? a_z_r : a_y_r;
    k_yb  = ctl.rot_x ? nsin_q : cos_q;
    op_za = ctl.rot_x ? a_y_r : a_z_r;
    k_za  = ctl.rot_x ? sin_q : cos_q;
    op_zb = ctl.rot_x ? a_z_r : a_x_r;
    k_zb  = ctl.rot_x ? cos_q : nsin_q;
    sc_op = a_x_r[COORD_W-1:0];

    pxa_nxt = a_x_r * cos_q;
    pxb_nxt = op_xb * k_xb;
    pya_nxt = op_ya * k_ya;
    pyb_nxt = op_yb * k_yb;
    pza_nxt = op_za * k_za;
    pzb_nxt = op_zb * k_zb;
    sp_nxt  = sc_op * scale_r;
  end

  always_ff @(posedge clk) begin
    if (mv_b) begin
      pxa_r    <= pxa_nxt;
      pxb_r    <= pxb_nxt;
      pya_r    <= pya_nxt;
      pyb_r    <= pyb_nxt;
      pza_r    <= pza_nxt;
      pzb_r    <= pzb_nxt;
      sp_r     <= sp_nxt;
      pass_x_r <= a_x_r;
      pass_y_r <= a_y_r;
      pass_z_r <= a_z_r;
    end
  end

  // stage C: sum and round, half toward plus infinity
  always_comb begin
    rs_x  = (PROD_W + 1)'(pxa_r) + (PROD_W + 1)'(pxb_r) + ROT_HALF;
    rs_y  = (PROD_W + 1)'(pya_r) + (PROD_W + 1)'(pyb_r) + ROT_HALF;
    rs_z  = (PROD_W + 1)'(pza_r) + (PROD_W + 1)'(pzb_r) + ROT_HALF;
    rsh_x = rs_x >>> TRIG_FRAC;
    rsh_y = rs_y >>> TRIG_FRAC;
    rsh_z = rs_z >>> TRIG_FRAC;
    ss    = sp_r + SC_HALF;
    ssh   = ss >>> FRAC_W;

    if (ctl.rot_y || ctl.rot_z) begin
      r_x_nxt = RND_W'(rsh_x);
    end else if (ctl.scale) begin
      r_x_nxt = RND_W'(ssh);
    end else begin
      r_x_nxt = RND_W'(pass_x_r);
    end
    r_y_nxt = (ctl.rot_x || ctl.rot_z) ? RND_W'(rsh_y) : RND_W'(pass_y_r);
    r_z_nxt = (ctl.rot_x || ctl.rot_y) ? RND_W'(rsh_z) : RND_W'(pass_z_r);
  end

  always_ff @(posedge clk) begin
    if (mv_c) begin
      r_x_r <= r_x_nxt;
      r_y_r <= r_y_nxt;
      r_z_r <= r_z_nxt;
    end
  end

  // stage D: pivot add-back and saturation
  always_comb begin
    pv_x  = ctl.pivot ? off_x_r : '0;
    pv_y  = ctl.pivot ? off_y_r : '0;
    pv_z  = ctl.pivot ? off_z_r : '0;
    sum_x = SUM_W'(r_x_r) + SUM_W'(pv_x);
    sum_y = SUM_W'(r_y_r) + SUM_W'(pv_y);
    sum_z = SUM_W'(r_z_r) + SUM_W'(pv_z);
  end

  always_ff @(posedge clk) begin
    if (mv_d) begin
      out_r.out_x <= saturate(sum_x);
      out_r.out_y <= saturate(sum_y);
      out_r.out_z <= saturate(sum_z);
    end
  end

  assign out_valid = v_d_r;
  assign out_data  = out_r;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v_a_r && v_b_r && v_c_r && v_d_r))
    else $error("input stalled while the pipeline has a free stage");

  a_held_stage_keeps_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (v_c_r && !mv_c) |=> v_c_r)
    else $error("held beat in rounding stage was dropped");

  a_mode_decode: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({ctl.translate, ctl.rot_x, ctl.rot_y, ctl.rot_z, ctl.scale}))
    else $error("mode decode selects no operation or several");

  a_pivot_rotates: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pivot |-> (ctl.rot_x || ctl.rot_y || ctl.rot_z))
    else $error("pivot set without a rotation");

endmodule

### bench/tb_vertex_axis_transform.sv
// Self-checking testbench for vertex_axis_transform against a transform predictor.
`timescale 1ns / 100ps

module tb_vertex_axis_transform
  import vat_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam longint C_MAXL = 64'sd2147483647;
  localparam longint C_MINL = -C_MAXL - 1;
  localparam logic [63:0] HALF_PI = 64'd1686629713;
  localparam int QTR = 1024;
  localparam int WDOG_LIMIT = 2000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vat_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vat_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  vertex_axis_transform dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mode_t cur_mode = MODE_TRANSLATE;
  logic [11:0] cur_angle = '0;
  logic signed [31:0] cur_off_x = '0;
  logic signed [31:0] cur_off_y = '0;
  logic signed [31:0] cur_off_z = '0;
  logic signed [31:0] cur_scale = 32'sd65536;

  int sin_tab [0:QTR];
  logic [11:0] angle_picks [10] = '{12'd0, 12'd1, 12'd512, 12'd1023, 12'd1024,
                                    12'd1025, 12'd2047, 12'd2048, 12'd3072, 12'd4095};

  vat_in_t vertex_q [$];
  vat_out_t xform_q [$];
  vat_out_t want;
  bit in_taken = 1'b0;
  int in_gap_left = 0;
  int out_stall_left = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int mismatch_cnt = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // quarter-wave sine magnitude, Taylor series in Q2.30 rounded to Q1.15
  function automatic int sine_mag(input int unsigned r);
    logic [63:0] arg;
    logic [63:0] term;
    logic [63:0] q15;
    longint acc;
    arg = (HALF_PI * 64'(r)) >> 10;
    term = arg;
    acc = longint'(arg);
    for (int k = 1; k <= 7; k++) begin
      term = ((((term * arg) >> 30) * arg) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q15 = (64'(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
    return (q15 > 64'd32767) ? 32767 : int'(q15);
  endfunction

  function automatic longint trig_q15(input logic [11:0] code);
    longint v;
    v = code[10] ? sin_tab[QTR - int'(code[9:0])] : sin_tab[code[9:0]];
    return code[11] ? -v : v;
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v);
    if (v > C_MAXL) begin
      return C_MAX;
    end else if (v < C_MINL) begin
      return C_MIN;
    end
    return v[31:0];
  endfunction

  function automatic vat_out_t transform_vertex(input vat_in_t v);
    longint x, y, z, ox, oy, oz, s, c, sf, rx, ry, rz;
    bit pivot;
    vat_out_t o;
    x = v.in_x;
    y = v.in_y;
    z = v.in_z;
    ox = cur_off_x;
    oy = cur_off_y;
    oz = cur_off_z;
    sf = cur_scale;
    s = trig_q15(cur_angle);
    c = trig_q15(cur_angle + 12'd1024);
    pivot = (cur_mode >= MODE_PIV_X) && (cur_mode <= MODE_PIV_Z);
    if (pivot) begin
      x = x - ox;
      y = y - oy;
      z = z - oz;
    end
    rx = x;
    ry = y;
    rz = z;
    case (cur_mode)
      MODE_TRANSLATE: begin
        rx = x + ox;
        ry = y + oy;
        rz = z + oz;
      end
      MODE_ROT_X, MODE_PIV_X: begin
        ry = (y * c - z * s + 64'sd16384) >>> 15;
        rz = (y * s + z * c + 64'sd16384) >>> 15;
      end
      MODE_ROT_Y, MODE_PIV_Y: begin
        rx = (x * c + z * s + 64'sd16384) >>> 15;
        rz = (z * c - x * s + 64'sd16384) >>> 15;
      end
      MODE_ROT_Z, MODE_PIV_Z: begin
        rx = (x * c - y * s + 64'sd16384) >>> 15;
        ry = (x * s + y * c + 64'sd16384) >>> 15;
      end
      default: begin
        rx = (x * sf + 64'sd32768) >>> 16;
      end
    endcase
    if (pivot) begin
      rx = rx + ox;
      ry = ry + oy;
      rz = rz + oz;
    end
    o.out_x = clamp_coord(rx);
    o.out_y = clamp_coord(ry);
    o.out_z = clamp_coord(rz);
    return o;
  endfunction

  // input beat accepted: record its expected result
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      xform_q.push_back(transform_vertex(in_data));
      void'(vertex_q.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      if (in_gap_left > 0) begin
        in_gap_left = in_gap_left - 1;
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < in_gap_pct) begin
        in_gap_left = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (vertex_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= vertex_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left = out_stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      out_stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (xform_q.size() == 0) begin
        $error("unexpected result beat x=%0d y=%0d z=%0d",
               out_data.out_x, out_data.out_y, out_data.out_z);
        mismatch_cnt++;
      end else begin
        want = xform_q.pop_front();
        if (out_data.out_x !== want.out_x) begin
          $error("out_x: expected %0d, got %0d", want.out_x, out_data.out_x);
          mismatch_cnt++;
        end
        if (out_data.out_y !== want.out_y) begin
          $error("out_y: expected %0d, got %0d", want.out_y, out_data.out_y);
          mismatch_cnt++;
        end
        if (out_data.out_z !== want.out_z) begin
          $error("out_z: expected %0d, got %0d", want.out_z, out_data.out_z);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MODE:     cur_mode = mode_t'(val[2:0]);
      REG_ANGLE:    cur_angle = val[11:0];
      REG_OFFSET_X: cur_off_x = val;
      REG_OFFSET_Y: cur_off_y = val;
      REG_OFFSET_Z: cur_off_z = val;
      REG_SCALE:    cur_scale = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z);
    vat_in_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    vertex_q.push_back(v);
  endtask

  task automatic drain();
    while (vertex_q.size() != 0 || xform_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0: return C_MAX;
        1: return C_MIN;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end else if (sel < 4) begin
      return $signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
    end
    return $urandom();
  endfunction

  function automatic logic signed [31:0] rand_scale();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000;
      2: return $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
      default: return $urandom_range(0, 1) ? C_MAX : C_MIN;
    endcase
  endfunction

  initial begin
    for (int r = 0; r <= QTR; r++) begin
      sin_tab[r] = sine_mag(r);
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: identity translation
    push_vertex(C_MAX, C_MIN, 32'sd0);
    push_vertex(-32'sd1, 32'sd1, C_MIN);
    drain();

    // translation into saturation both ways
    write_reg(REG_OFFSET_X, C_MAX);
    write_reg(REG_OFFSET_Y, C_MIN);
    write_reg(REG_OFFSET_Z, -32'sd1);
    push_vertex(C_MAX, C_MIN, C_MIN);
    push_vertex(C_MIN, C_MAX, 32'sd0);
    drain();

    // scale with the reset factor, junk above the mode bits
    write_reg(REG_MODE, 32'hdead_bee8 | 32'(MODE_SCALE_X));
    push_vertex(-32'sd1, 32'sd7, -32'sd7);
    push_vertex(C_MIN, C_MAX, 32'sd4);
    drain();

    // most negative factor overflows; half factor checks rounding toward +inf
    write_reg(REG_SCALE, C_MIN);
    push_vertex(C_MIN, 32'sd0, 32'sd0);
    push_vertex(C_MAX, 32'sd1, 32'sd2);
    drain();
    write_reg(REG_SCALE, 32'sh0000_8000);
    push_vertex(32'sd1, 32'sd0, 32'sd0);
    push_vertex(-32'sd1, 32'sd0, 32'sd0);
    drain();

    // quarter turn about each axis through the origin
    write_reg(REG_ANGLE, 32'd1024);
    for (int m = MODE_ROT_X; m <= MODE_ROT_Z; m++) begin
      write_reg(REG_MODE, 32'(m));
      push_vertex(C_MAX, C_MIN, 32'sd12345);
      drain();
    end

    // half turn about a far pivot: the difference needs a 33rd bit
    write_reg(REG_OFFSET_X, C_MIN);
    write_reg(REG_OFFSET_Y, C_MAX);
    write_reg(REG_OFFSET_Z, C_MIN);
    write_reg(REG_ANGLE, 32'd2048);
    for (int m = MODE_PIV_X; m <= MODE_PIV_Z; m++) begin
      write_reg(REG_MODE, 32'(m));
      push_vertex(C_MAX, C_MIN, C_MAX);
      drain();
    end

    // eighth turn from a code with junk upper bits; spare indexes must be ignored
    write_reg(REG_ANGLE, 32'habcd_e200);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    write_reg(REG_MODE, 32'(MODE_ROT_Z));
    push_vertex(C_MAX, C_MIN, 32'sd0);
    push_vertex(C_MIN, C_MIN, -32'sd1);
    drain();

    for (int p = 0; p < 30; p++) begin
      if (p >= 26) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: in_gap_pct = 0;
          1: in_gap_pct = 5;
          default: in_gap_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0: out_stall_pct = 0;
          1: out_stall_pct = 5;
          default: out_stall_pct = 25;
        endcase
      end
      write_reg(REG_MODE, ($urandom() << 3) | 32'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_ANGLE, ($urandom() << 12) | 32'(angle_picks[$urandom_range(0, 9)]));
      end else begin
        write_reg(REG_ANGLE, $urandom());
      end
      write_reg(REG_OFFSET_X, rand_coord());
      write_reg(REG_OFFSET_Y, rand_coord());
      write_reg(REG_OFFSET_Z, rand_coord());
      write_reg(REG_SCALE, rand_scale());
      if ($urandom_range(0, 4) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
      end
      for (int i = 0; i < 31; i++) begin
        push_vertex(rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
